>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared types and constants for the stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW       = 7;
  localparam int unsigned AddrW      = 6;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_MOD   = 3'd5,
    OP_POP   = 3'd6,
    OP_CLEAR = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_ZDIV = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [6:0]         depth;
  } out_item_t;

  // Request to the divider: mod_mode selects integer remainder.
  typedef struct packed {
    logic               start;
    logic               mod_mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } div_rsp_t;

endpackage

>>> rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN divider
// Restoring divider, one quotient bit per cycle, for divide and modulo.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t rsp_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        mod_q, mod_d;
  logic        nega_q, nega_d, negq_q, negq_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic        done_q;
  logic [31:0] res_q, res_d;

  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] ua, ub;
  logic [15:0] ia, ib;
  logic [47:0] qmag;
  logic [31:0] rmod;

  always_comb begin
    ua = req_i.a[31] ? 32'(-req_i.a) : req_i.a;
    ub = req_i.b[31] ? 32'(-req_i.b) : req_i.b;
    ia = ua[31:16];
    ib = ub[31:16];
    shifted = {rem_q[31:0], quo_q[47]};
    trial   = shifted - {1'b0, den_q};
    qmag    = quo_q;
    rmod    = {rem_q[15:0], 16'h0};

    busy_d = busy_q;
    cnt_d  = cnt_q;
    mod_d  = mod_q;
    nega_d = nega_q;
    negq_d = negq_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      mod_d  = req_i.mod_mode;
      nega_d = req_i.a[31];
      negq_d = req_i.a[31] ^ req_i.b[31];
      rem_d  = '0;
      if (req_i.mod_mode) begin
        // Integer parts only; 16 steps suffice for the 16-bit dividend.
        quo_d = {ia, 32'h0};
        den_d = {16'h0, ib};
        cnt_d = 6'd16;
      end else begin
        quo_d = {ua, 16'h0};
        den_d = ub;
        cnt_d = 6'd48;
      end
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  // Finish stage: saturate or sign the result once iterations end.
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      fin_q  <= busy_q && !busy_d;
      done_q <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    nega_q <= nega_d;
    negq_q <= negq_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    if (fin_q) begin
      if (mod_q) begin
        res_q <= nega_q ? 32'(-rmod) : rmod;
      end else if (negq_q) begin
        res_q <= (qmag > 48'h8000_0000) ? 32'h8000_0000 : 32'(-qmag);
      end else begin
        res_q <= (qmag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : qmag[31:0];
      end
    end else begin
      res_q <= res_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

>>> rtl/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Reverse Polish calculator on Q16.16 values with a 64-entry stack memory.
// ----------------------------------------------------------------------------
// Usage: an input beat carries an opcode and an operand; each beat yields
// exactly one output beat with value, status and depth. Both channels use
// valid and stall; a beat moves when valid is high and stall is low.
// The stack lives in a synchronous memory with a registered read, so
// every item first reads its top one or two entries, then computes and
// writes back. After acceptance, push, pop, clear and any refused item
// pass through states RD1 and OUT; add, subtract and a zero divisor pass
// through RD1, RD2, EXE and OUT; multiply adds MUL after EXE, and divide
// and modulo add DIV, where the one-bit-per-cycle divider runs 16 steps
// for modulo and 48 for divide. The result beat is then offered from the
// output register. One item is worked on at a time: the input stalls from
// acceptance until the result beat has been taken.
// The result sits in an output register; while the receiver stalls it
// holds steady and no new item is taken.
// Reset clears the stack pointer and all control state; store contents
// are left as they are and are only read below the pointer.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpn_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpn_pkg::out_item_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [6:0] sp_q, sp_d;
  logic [2:0] op_q;
  logic signed [31:0] opnd_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] prod_q;
  rpn_pkg::out_item_t out_q, out_d;
  logic out_valid_q;

  logic signed [31:0] mem [rpn_pkg::StackDepth];
  logic signed [31:0] rdata_q;
  logic [5:0] raddr;
  logic       we;
  logic [5:0] waddr;
  logic signed [31:0] wdata;

  rpn_pkg::div_req_t div_req;
  rpn_pkg::div_rsp_t div_rsp;

  rpn_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  logic signed [32:0] sum;
  logic signed [47:0] mulsh;
  logic signed [31:0] mulres;
  logic signed [31:0] addres;
  logic [15:0] ibm;
  logic two_ok;

  always_comb begin
    sum    = (op_q == rpn_pkg::OP_SUB) ? (33'(a_q) - 33'(b_q)) : (33'(a_q) + 33'(b_q));
    addres = (sum > 33'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (sum < -33'sh8000_0000) ? 32'sh8000_0000 : sum[31:0];
    mulsh  = prod_q[63:16]; // arithmetic shift floors
    mulres = (mulsh > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (mulsh < -48'sh8000_0000) ? 32'sh8000_0000 : mulsh[31:0];
    ibm    = b_q[31] ? 16'(32'(-b_q) >> 16) : b_q[31:16];
    two_ok = sp_q >= 7'd2;
  end

  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    out_d   = out_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = 6'(sp_q - 7'd1);
    div_req = '0;
    div_req.a = a_q;
    div_req.b = b_q;
    div_req.mod_mode = (op_q == rpn_pkg::OP_MOD);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        // Top entry is being read; fetch the one below next.
        raddr   = 6'(sp_q - 7'd2);
        state_d = S_RD2;
        out_d.depth = sp_q;
        case (op_q)
          rpn_pkg::OP_PUSH: begin
            if (sp_q >= 7'(rpn_pkg::StackDepth)) begin
              out_d.status = rpn_pkg::ST_FULL;
              out_d.value  = rdata_q;
            end else begin
              we    = 1'b1;
              waddr = sp_q[5:0];
              wdata = opnd_q;
              sp_d  = sp_q + 7'd1;
              out_d.status = rpn_pkg::ST_OK;
              out_d.value  = opnd_q;
              out_d.depth  = sp_q + 7'd1;
            end
            state_d = S_OUT;
          end
          rpn_pkg::OP_CLEAR: begin
            sp_d = '0;
            out_d = '0;
            state_d = S_OUT;
          end
          rpn_pkg::OP_POP: begin
            if (sp_q == 7'd0) begin
              out_d.status = rpn_pkg::ST_FEW;
              out_d.value  = '0;
            end else begin
              sp_d = sp_q - 7'd1;
              out_d.status = rpn_pkg::ST_OK;
              out_d.value  = rdata_q;
              out_d.depth  = sp_q - 7'd1;
            end
            state_d = S_OUT;
          end
          default: begin
            if (!two_ok) begin
              out_d.status = rpn_pkg::ST_FEW;
              out_d.value  = (sp_q == 7'd0) ? 32'sd0 : rdata_q;
              state_d = S_OUT;
            end
          end
        endcase
        if (op_q == rpn_pkg::OP_PUSH && sp_q == 7'd0) begin
          out_d.value = (sp_q >= 7'(rpn_pkg::StackDepth)) ? rdata_q : opnd_q;
        end
      end
      S_RD2: begin
        state_d = S_EXE;
      end
      S_EXE: begin
        // a_q holds the second entry, b_q the top.
        case (op_q)
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
            we = 1'b1; waddr = 6'(sp_q - 7'd2); wdata = addres;
            sp_d = sp_q - 7'd1;
            out_d = '{value: addres, status: rpn_pkg::ST_OK, depth: sp_q - 7'd1};
            state_d = S_OUT;
          end
          rpn_pkg::OP_MUL: state_d = S_MUL;
          default: begin
            if ((op_q == rpn_pkg::OP_DIV && b_q == 32'sd0) ||
                (op_q == rpn_pkg::OP_MOD && ibm == 16'd0)) begin
              // Drop only the divisor; the second entry becomes the top.
              sp_d = sp_q - 7'd1;
              out_d = '{value: a_q, status: rpn_pkg::ST_ZDIV, depth: sp_q - 7'd1};
              state_d = S_OUT;
            end else begin
              div_req.start = 1'b1;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        we = 1'b1; waddr = 6'(sp_q - 7'd2); wdata = mulres;
        sp_d = sp_q - 7'd1;
        out_d = '{value: mulres, status: rpn_pkg::ST_OK, depth: sp_q - 7'd1};
        state_d = S_OUT;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          we = 1'b1; waddr = 6'(sp_q - 7'd2); wdata = div_rsp.result;
          sp_d = sp_q - 7'd1;
          out_d = '{value: div_rsp.result, status: rpn_pkg::ST_OK, depth: sp_q - 7'd1};
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (state_q == S_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      op_q   <= in_data_i.opcode;
      opnd_q <= in_data_i.operand;
    end
    if (state_q == S_RD1) begin
      b_q <= rdata_q;
    end
    if (state_q == S_RD2) begin
      a_q <= rdata_q;
    end
    prod_q <= 64'(a_q) * 64'(b_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/rpn_checker.sv
// ----------------------------------------------------------------------------
// RPN port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rpn_pkg::out_item_t out_data_o
);

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No new item is taken while a result is waiting.
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken with result pending");

  // Depth never exceeds the stack size.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.depth <= 7'd64)
    else $error("depth out of range");

  // An item refused on an empty stack reports a zero value.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.depth == 7'd0 && out_data_o.status == rpn_pkg::ST_FEW
      |-> out_data_o.value == 32'sd0)
    else $error("empty stack value not zero");

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

>>> tb/sv/tb_rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// RPN stack calculator core testbench
// Drives opcode/operand beats through a directed table and random phases,
// predicts every result with a behavioural stack model and checks each
// output beat field by field under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator_core;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned NumRandom     = 760;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  rpn_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rpn_pkg::out_item_t out_data_o;

  rpn_stack_calculator_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic signed [31:0] calc_stack [rpn_pkg::StackDepth];
  int unsigned        calc_sp;
  rpn_pkg::out_item_t pending_results [$];

  int unsigned errors;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_off;
  int unsigned quiet_cycles = 0;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] top_or_zero();
    return (calc_sp == 0) ? 32'sd0 : calc_stack[calc_sp-1];
  endfunction

  // Computes the result of one item and updates the predicted stack.
  function automatic rpn_pkg::out_item_t calc_step(input rpn_pkg::in_item_t it);
    rpn_pkg::out_item_t r;
    logic signed [31:0] a, b, res;
    logic signed [65:0] wide;
    logic signed [63:0] ia, ib;
    r = '0;
    r.status = rpn_pkg::ST_OK;
    case (rpn_pkg::op_e'(it.opcode))
      rpn_pkg::OP_PUSH: begin
        if (calc_sp >= rpn_pkg::StackDepth) begin
          r.status = rpn_pkg::ST_FULL;
          r.value  = top_or_zero();
        end else begin
          calc_stack[calc_sp] = it.operand;
          calc_sp++;
          r.value = it.operand;
        end
      end
      rpn_pkg::OP_CLEAR: begin
        calc_sp = 0;
        r.value = '0;
      end
      rpn_pkg::OP_POP: begin
        if (calc_sp == 0) begin
          r.status = rpn_pkg::ST_FEW;
          r.value  = '0;
        end else begin
          calc_sp--;
          r.value = calc_stack[calc_sp];
        end
      end
      default: begin
        if (calc_sp < 2) begin
          r.status = rpn_pkg::ST_FEW;
          r.value  = top_or_zero();
        end else begin
          b = calc_stack[calc_sp-1];
          a = calc_stack[calc_sp-2];
          r.status = rpn_pkg::ST_OK;
          res = '0;
          case (rpn_pkg::op_e'(it.opcode))
            rpn_pkg::OP_ADD: res = sat32(66'(a) + 66'(b));
            rpn_pkg::OP_SUB: res = sat32(66'(a) - 66'(b));
            // Arithmetic shift floors toward minus infinity.
            rpn_pkg::OP_MUL: begin
              wide = (66'(a) * 66'(b)) >>> 16;
              res  = sat32(wide);
            end
            rpn_pkg::OP_DIV: begin
              if (b == 0) r.status = rpn_pkg::ST_ZDIV;
              else res = sat32((66'(a) * 66'sd65536) / 66'(b));
            end
            default: begin
              ia = 64'(a) / 64'sd65536;
              ib = 64'(b) / 64'sd65536;
              if (ib == 0) r.status = rpn_pkg::ST_ZDIV;
              else res = 32'((ia % ib) * 64'sd65536);
            end
          endcase
          calc_sp--;
          if (r.status == rpn_pkg::ST_ZDIV) begin
            r.value = top_or_zero();
          end else begin
            calc_stack[calc_sp-1] = res;
            r.value = res;
          end
        end
      end
    endcase
    r.depth = 7'(calc_sp);
    return r;
  endfunction

  // Directed table; an expected value is given only where it is obvious.
  typedef struct {
    rpn_pkg::op_e       opc;
    logic signed [31:0] operand;
    bit                 known;
    logic signed [31:0] value;
    rpn_pkg::status_e   status;
    logic [6:0]         depth;
  } dir_row_t;

  localparam int unsigned NumDir = 22;
  dir_row_t dir_rows [NumDir] = '{
    '{rpn_pkg::OP_POP,   32'sd0,        1, 32'sd0,        rpn_pkg::ST_FEW,  7'd0},
    '{rpn_pkg::OP_ADD,   32'sd0,        1, 32'sd0,        rpn_pkg::ST_FEW,  7'd0},
    '{rpn_pkg::OP_PUSH,  32'sh7fffffff, 1, 32'sh7fffffff, rpn_pkg::ST_OK,   7'd1},
    '{rpn_pkg::OP_MUL,   32'sd0,        1, 32'sh7fffffff, rpn_pkg::ST_FEW,  7'd1},
    '{rpn_pkg::OP_PUSH,  32'sh7fffffff, 1, 32'sh7fffffff, rpn_pkg::ST_OK,   7'd2},
    '{rpn_pkg::OP_ADD,   32'sd0,        1, 32'sh7fffffff, rpn_pkg::ST_OK,   7'd1},
    '{rpn_pkg::OP_PUSH,  32'sh80000000, 1, 32'sh80000000, rpn_pkg::ST_OK,   7'd2},
    '{rpn_pkg::OP_SUB,   32'shffffffff, 0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_PUSH,  32'sh80000000, 0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_MUL,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_PUSH,  32'sd0,        0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_DIV,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_ZDIV, 7'd0},
    '{rpn_pkg::OP_PUSH,  32'sh00008000, 0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_MOD,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_ZDIV, 7'd0},
    '{rpn_pkg::OP_PUSH,  -32'sd458752,  0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_PUSH,  32'sd196608,   0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_MOD,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_PUSH,  32'sh00030000, 0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_DIV,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_POP,   32'sd0,        0, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_CLEAR, 32'sd0,        1, 32'sd0,        rpn_pkg::ST_OK,   7'd0},
    '{rpn_pkg::OP_POP,   32'sd0,        1, 32'sd0,        rpn_pkg::ST_FEW,  7'd0}
  };

  always @(posedge clk_i) begin
    rpn_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: value %0d", out_data_o.value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, out_data_o.value);
          errors++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.depth !== exp_r.depth) begin
          $error("depth: expected %0d, got %0d", exp_r.depth, out_data_o.depth);
          errors++;
        end
      end
    end
  end

  // Receiver stall; a long hold-off fills the block while the sender waits.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic rpn_pkg::in_item_t random_item(input int unsigned phase_depth);
    rpn_pkg::in_item_t it;
    int unsigned       pick;
    pick = $urandom_range(99);
    it.operand = $urandom;
    if (pick < 5) it.opcode = rpn_pkg::OP_CLEAR;
    else if (pick < 40 + (phase_depth < 4 ? 20 : 0)) it.opcode = rpn_pkg::OP_PUSH;
    else it.opcode = 3'($urandom_range(1, 6));
    case ($urandom_range(9))
      0: it.operand = 32'sh7fffffff;
      1: it.operand = 32'sh80000000;
      2: it.operand = 32'sd0;
      3: it.operand = $signed(32'($urandom_range(0, 15)) << 16) - 32'sd458752;
      4: it.operand = 32'($urandom_range(0, 65535));
      default: ;
    endcase
    return it;
  endfunction

  // Entry point.
  initial begin
    rpn_pkg::in_item_t  it;
    rpn_pkg::out_item_t er;
    int unsigned        k, n;
    errors = 0; idle_pct = 0; stall_pct = 0; hold_off = 0;
    calc_sp = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NumDir; k++) begin
      it.opcode  = dir_rows[k].opc;
      it.operand = dir_rows[k].operand;
      er = calc_step(it);
      if (dir_rows[k].known) begin
        if (er.value !== dir_rows[k].value) begin
          $error("row %0d value: expected %0d, got %0d", k, dir_rows[k].value, er.value);
          errors++;
        end
        if (er.status !== dir_rows[k].status) begin
          $error("row %0d status: expected %0d, got %0d", k, dir_rows[k].status,
                 er.status);
          errors++;
        end
        if (er.depth !== dir_rows[k].depth) begin
          $error("row %0d depth: expected %0d, got %0d", k, dir_rows[k].depth, er.depth);
          errors++;
        end
      end
      pending_results.push_back(er);
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end

    // Fill past the top to reach the full-stack case.
    for (k = 0; k < rpn_pkg::StackDepth + 2; k++) begin
      it.opcode = rpn_pkg::OP_PUSH;
      it.operand = $urandom;
      pending_results.push_back(calc_step(it));
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end

    for (n = 0; n < NumRandom; n++) begin
      case ((n * 5) / NumRandom)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        3: begin idle_pct = 10; stall_pct = 10; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (n == NumRandom / 2) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      it = random_item(calc_sp);
      if (!hold_off && ($urandom_range(99) < idle_pct)) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      end
      pending_results.push_back(calc_step(it));
      in_valid_i <= 1'b1;
      in_data_i  <= it;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
